@@ src/dcsv_pkg.sv @@
// Package for the DAG-CBOR stream validator.
// Sizes, result and error codes, and the controller/datapath structs.
// No dependencies.
package dcsv_pkg;

  localparam int MaxNest      = 16;
  localparam int MaxKeyLen    = 64;
  localparam int LvlW         = $clog2(MaxNest + 1);
  localparam int KeyPosW      = $clog2(MaxKeyLen);
  localparam int KeyLenW      = $clog2(MaxKeyLen + 1);
  localparam int KeyStoreDepth = (MaxNest + 1) * MaxKeyLen;
  localparam int KeyAddrW     = LvlW + KeyPosW;

  localparam logic [1:0] PhHead = 2'd0;
  localparam logic [1:0] PhArg  = 2'd1;
  localparam logic [1:0] PhStr  = 2'd2;

  localparam logic [1:0] KindHead  = 2'd0;
  localparam logic [1:0] KindBytes = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  localparam logic [3:0] ErrNone       = 4'd0;
  localparam logic [3:0] ErrTruncated  = 4'd1;
  localparam logic [3:0] ErrNonMinimal = 4'd2;
  localparam logic [3:0] ErrBadInfo    = 4'd3;
  localparam logic [3:0] ErrBadSimple  = 4'd4;
  localparam logic [3:0] ErrBadTag     = 4'd5;
  localparam logic [3:0] ErrTagNotBytes = 4'd6;
  localparam logic [3:0] ErrKeyNotText = 4'd7;
  localparam logic [3:0] ErrKeyOrder   = 4'd8;
  localparam logic [3:0] ErrTooDeep    = 4'd9;
  localparam logic [3:0] ErrKeyTooLong = 4'd10;

  localparam logic [2:0] MajBytes = 3'd2;
  localparam logic [2:0] MajText  = 3'd3;
  localparam logic [2:0] MajArray = 3'd4;
  localparam logic [2:0] MajMap   = 3'd5;
  localparam logic [2:0] MajTag   = 3'd6;
  localparam logic [2:0] MajSimple = 3'd7;

  localparam logic [63:0] TagCid = 64'd42;

  typedef struct packed {
    logic accept;
    logic proc;
    logic pop;
    logic emit;
  } dcsv_cmd_t;

  typedef struct packed {
    logic hold;
    logic need_pop;
    logic pop_last;
    logic emit_valid;
    logic out_busy;
  } dcsv_sts_t;

endpackage

@@ src/dcsv_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module dcsv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/dcsv_ctrl.sv @@
// Sequencing controller for the DAG-CBOR stream validator.
// Depends on dcsv_pkg.
module dcsv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dcsv_pkg::dcsv_sts_t sts_i,
  output dcsv_pkg::dcsv_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StProc = 2'd1;
  localparam logic [1:0] StPop  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = StProc;
      end
      StProc: begin
        cmd_o.proc = 1'b1;
        if (sts_i.hold) state_d = StIdle;
        else if (sts_i.need_pop) state_d = StPop;
        else state_d = StEmit;
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        if (sts_i.pop_last) state_d = StEmit;
      end
      StEmit: begin
        if (!(sts_i.emit_valid && sts_i.out_busy)) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/dcsv_datapath.sv @@
// Datapath of the DAG-CBOR stream validator: head decoder, nesting stack,
// key store and result register. Depends on dcsv_pkg and dcsv_ram.
module dcsv_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcsv_pkg::dcsv_cmd_t cmd_i,
  output dcsv_pkg::dcsv_sts_t sts_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_buffer_i,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          result_kind_o,
  output logic [2:0]          major_type_o,
  output logic [63:0]         argument_o,
  output logic [7:0]          payload_byte_o,
  output logic [4:0]          nest_level_o,
  output logic                is_map_key_o,
  output logic                object_done_o,
  output logic [31:0]         bytes_consumed_o,
  output logic [3:0]          error_code_o
);

  localparam int Lvls = dcsv_pkg::MaxNest + 1;
  localparam int LW   = dcsv_pkg::LvlW;
  localparam int KLW  = dcsv_pkg::KeyLenW;

  logic [4:0]  max_depth_q;
  logic [7:0]  byte_q;
  logic        end_q;
  logic [1:0]  phase_q, phase_d;
  logic [63:0] head_shift_q, head_shift_d;
  logic [63:0] head_floor_q, head_floor_d;
  logic [3:0]  hbl_q, hbl_d;
  logic [2:0]  cur_major_q, cur_major_d;
  logic [63:0] str_left_q, str_left_d;
  logic [63:0] cnt_q [Lvls];
  logic [63:0] cnt_d [Lvls];
  logic        is_map_q [Lvls];
  logic        is_map_d [Lvls];
  logic        wv_q [Lvls];
  logic        wv_d [Lvls];
  logic        has_key_q [Lvls];
  logic        has_key_d [Lvls];
  logic [KLW-1:0] klen_q [Lvls];
  logic [KLW-1:0] klen_d [Lvls];
  logic        kc_q, kc_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic        tag_q, tag_d;
  logic [31:0] cons_q, cons_d;
  logic        hold_q, hold_d;
  logic        done_q, done_d;

  logic        pv_q, pv_d;
  logic [1:0]  pkind_q, pkind_d;
  logic [2:0]  pmaj_q, pmaj_d;
  logic [63:0] parg_q, parg_d;
  logic [7:0]  ppb_q, ppb_d;
  logic [LW-1:0] plvl_q, plvl_d;
  logic        pkey_q, pkey_d;
  logic [3:0]  perr_q, perr_d;

  logic        ov_q, ov_d;
  logic [1:0]  okind_q, okind_d;
  logic [2:0]  omaj_q, omaj_d;
  logic [63:0] oarg_q, oarg_d;
  logic [7:0]  opb_q, opb_d;
  logic [LW-1:0] olvl_q, olvl_d;
  logic        okey_q, okey_d;
  logic        odone_q, odone_d;
  logic [31:0] ocons_q, ocons_d;
  logic [3:0]  oerr_q, oerr_d;

  logic        at_key;
  logic [dcsv_pkg::KeyPosW-1:0] kpos;
  logic [dcsv_pkg::KeyAddrW-1:0] kaddr;
  logic [7:0]  kprev;
  logic        kwe;

  logic [2:0]  maj;
  logic [4:0]  info;
  logic [3:0]  err;
  logic        res;
  logic [1:0]  rkind;
  logic        hd_go;
  logic [63:0] hd_arg;
  logic [63:0] hs;
  logic        fin;
  logic [4:0]  limit;
  logic [63:0] cdec;
  logic        trunc;
  logic        fin_valid;
  logic        fin_err;
  logic        restart;
  logic [LW-1:0] lvl_up;

  assign at_key = is_map_q[lvl_q] && !wv_q[lvl_q];
  assign kpos   = klen_q[lvl_q][dcsv_pkg::KeyPosW-1:0] - str_left_q[dcsv_pkg::KeyPosW-1:0];
  assign kaddr  = {lvl_q, kpos};
  assign limit  = (max_depth_q > 5'(dcsv_pkg::MaxNest)) ? 5'(dcsv_pkg::MaxNest) : max_depth_q;
  assign lvl_up = lvl_q + 1'b1;
  assign cdec   = cnt_q[lvl_q] - 64'd1;

  dcsv_ram #(
    .Width(8),
    .Depth(dcsv_pkg::KeyStoreDepth)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (kwe),
    .waddr_i(kaddr),
    .wdata_i(byte_q),
    .re_i   (cmd_i.accept),
    .raddr_i(kaddr),
    .rdata_o(kprev)
  );

  // end-of-step fields, after any pops
  assign trunc     = end_q && !done_q && !(pv_q && pkind_q == dcsv_pkg::KindError);
  assign fin_valid = pv_q || trunc;
  assign fin_err   = trunc || (pv_q && pkind_q == dcsv_pkg::KindError);

  always_comb begin
    phase_d = phase_q; head_shift_d = head_shift_q; head_floor_d = head_floor_q;
    hbl_d = hbl_q; cur_major_d = cur_major_q; str_left_d = str_left_q;
    cnt_d = cnt_q; is_map_d = is_map_q; wv_d = wv_q; has_key_d = has_key_q;
    klen_d = klen_q; kc_d = kc_q; lvl_d = lvl_q; tag_d = tag_q; cons_d = cons_q;
    hold_d = hold_q; done_d = done_q;
    pv_d = pv_q; pkind_d = pkind_q; pmaj_d = pmaj_q; parg_d = parg_q; ppb_d = ppb_q;
    plvl_d = plvl_q; pkey_d = pkey_q; perr_d = perr_q;
    ov_d = ov_q && !out_ready_i; okind_d = okind_q; omaj_d = omaj_q; oarg_d = oarg_q;
    opb_d = opb_q; olvl_d = olvl_q; okey_d = okey_q; odone_d = odone_q;
    ocons_d = ocons_q; oerr_d = oerr_q;
    maj = (phase_q == dcsv_pkg::PhHead) ? byte_q[7:5] : cur_major_q;
    info = byte_q[4:0];
    err = dcsv_pkg::ErrNone; res = 1'b0; rkind = dcsv_pkg::KindHead;
    hd_go = 1'b0; hd_arg = 64'd0; hs = {head_shift_q[55:0], byte_q};
    fin = 1'b0; kwe = 1'b0; restart = 1'b0;

    if (cmd_i.proc) begin
      if (hold_q) begin
        restart = end_q;
      end else begin
        if (cons_q != '1) cons_d = cons_q + 32'd1;
        done_d = 1'b0;
        case (phase_q)
          dcsv_pkg::PhArg: begin
            head_shift_d = hs;
            hbl_d = hbl_q - 4'd1;
            if (hbl_q == 4'd1) begin
              phase_d = dcsv_pkg::PhHead;
              if (hs < head_floor_q) err = dcsv_pkg::ErrNonMinimal;
              else begin
                hd_go  = 1'b1;
                hd_arg = hs;
              end
            end
          end
          dcsv_pkg::PhStr: begin
            if (at_key && !kc_q && byte_q < kprev) begin
              err = dcsv_pkg::ErrKeyOrder;
            end else begin
              if (at_key) begin
                kwe = 1'b1;
                if (!kc_q && byte_q > kprev) kc_d = 1'b1;
              end
              str_left_d = str_left_q - 64'd1;
              if (str_left_q == 64'd1) begin
                phase_d = dcsv_pkg::PhHead;
                if (at_key && !kc_d) err = dcsv_pkg::ErrKeyOrder;
                else begin
                  res = 1'b1; rkind = dcsv_pkg::KindBytes; fin = 1'b1;
                end
              end else begin
                res = 1'b1; rkind = dcsv_pkg::KindBytes;
              end
            end
          end
          default: begin
            cur_major_d = maj;
            if (at_key && maj != dcsv_pkg::MajText) err = dcsv_pkg::ErrKeyNotText;
            else if (tag_q && maj != dcsv_pkg::MajBytes) err = dcsv_pkg::ErrTagNotBytes;
            else begin
              head_shift_d = 64'd0;
              if (maj == dcsv_pkg::MajSimple) begin
                if (info inside {5'd20, 5'd21, 5'd22}) begin
                  hd_go = 1'b1; hd_arg = 64'(info); head_shift_d = 64'(info);
                end else if (info != 5'd27) err = dcsv_pkg::ErrBadSimple;
                else begin
                  hbl_d = 4'd8; head_floor_d = 64'd0; phase_d = dcsv_pkg::PhArg;
                end
              end else if (info < 5'd24) begin
                hd_go = 1'b1; hd_arg = 64'(info); head_shift_d = 64'(info);
              end else if (info > 5'd27) err = dcsv_pkg::ErrBadInfo;
              else begin
                phase_d = dcsv_pkg::PhArg;
                case (info)
                  5'd24: begin hbl_d = 4'd1; head_floor_d = 64'd24; end
                  5'd25: begin hbl_d = 4'd2; head_floor_d = 64'h100; end
                  5'd26: begin hbl_d = 4'd4; head_floor_d = 64'h10000; end
                  default: begin hbl_d = 4'd8; head_floor_d = 64'h1_0000_0000; end
                endcase
              end
            end
          end
        endcase

        if (hd_go) begin
          case (maj)
            dcsv_pkg::MajBytes, dcsv_pkg::MajText: begin
              if (at_key) begin
                if (hd_arg > 64'(dcsv_pkg::MaxKeyLen)) err = dcsv_pkg::ErrKeyTooLong;
                else if (has_key_q[lvl_q] && hd_arg < 64'(klen_q[lvl_q]))
                  err = dcsv_pkg::ErrKeyOrder;
                else if (has_key_q[lvl_q] && hd_arg == 64'(klen_q[lvl_q]) && hd_arg == 64'd0)
                  err = dcsv_pkg::ErrKeyOrder;
                else begin
                  kc_d = !(has_key_q[lvl_q] && hd_arg == 64'(klen_q[lvl_q]));
                  has_key_d[lvl_q] = 1'b1;
                  klen_d[lvl_q] = hd_arg[KLW-1:0];
                end
              end else begin
                tag_d = 1'b0;
              end
              if (err == dcsv_pkg::ErrNone) begin
                res = 1'b1;
                if (hd_arg == 64'd0) fin = 1'b1;
                else begin
                  phase_d = dcsv_pkg::PhStr; str_left_d = hd_arg;
                end
              end
            end
            dcsv_pkg::MajArray, dcsv_pkg::MajMap: begin
              if (hd_arg != 64'd0 && {1'b0, lvl_q} + 6'd1 > {1'b0, limit})
                err = dcsv_pkg::ErrTooDeep;
              else begin
                res = 1'b1;
                if (hd_arg == 64'd0) fin = 1'b1;
                else begin
                  lvl_d = lvl_up;
                  cnt_d[lvl_up] = hd_arg;
                  is_map_d[lvl_up] = (maj == dcsv_pkg::MajMap);
                  wv_d[lvl_up] = 1'b0;
                  has_key_d[lvl_up] = 1'b0;
                  klen_d[lvl_up] = '0;
                end
              end
            end
            dcsv_pkg::MajTag: begin
              if (hd_arg != dcsv_pkg::TagCid) err = dcsv_pkg::ErrBadTag;
              else begin
                tag_d = 1'b1; res = 1'b1;
              end
            end
            default: begin
              res = 1'b1; fin = 1'b1;
            end
          endcase
        end

        pv_d   = res || (err != dcsv_pkg::ErrNone);
        pkind_d = (err != dcsv_pkg::ErrNone) ? dcsv_pkg::KindError : rkind;
        pmaj_d = maj;
        parg_d = (err == dcsv_pkg::ErrNone && rkind == dcsv_pkg::KindHead) ? hd_arg : 64'd0;
        ppb_d  = (err == dcsv_pkg::ErrNone && rkind == dcsv_pkg::KindBytes) ? byte_q : 8'd0;
        plvl_d = lvl_q;
        pkey_d = at_key;
        perr_d = err;
      end
    end

    if (cmd_i.pop) begin
      if (is_map_q[lvl_q] && !wv_q[lvl_q]) begin
        wv_d[lvl_q] = 1'b1;
      end else begin
        wv_d[lvl_q] = 1'b0;
        cnt_d[lvl_q] = cdec;
        if (cdec == 64'd0) begin
          if (lvl_q == '0) done_d = 1'b1;
          else lvl_d = lvl_q - 1'b1;
        end
      end
    end

    if (cmd_i.emit) begin
      if (fin_valid) begin
        ov_d = 1'b1;
        if (trunc) begin
          okind_d = dcsv_pkg::KindError; omaj_d = cur_major_q; oarg_d = 64'd0;
          opb_d = 8'd0; olvl_d = lvl_q; okey_d = at_key; odone_d = 1'b0;
          oerr_d = dcsv_pkg::ErrTruncated;
        end else begin
          okind_d = pkind_q; omaj_d = pmaj_q; oarg_d = parg_q; opb_d = ppb_q;
          olvl_d = plvl_q; okey_d = pkey_q; odone_d = done_q; oerr_d = perr_q;
        end
        ocons_d = cons_q;
      end
      if (fin_err && !end_q) hold_d = 1'b1;
      else if (end_q || done_q) restart = 1'b1;
    end

    if (restart) begin
      phase_d = dcsv_pkg::PhHead; head_shift_d = 64'd0; head_floor_d = 64'd0;
      hbl_d = 4'd0; cur_major_d = 3'd0; str_left_d = 64'd0;
      cnt_d[0] = 64'd1; is_map_d[0] = 1'b0; wv_d[0] = 1'b0;
      has_key_d[0] = 1'b0; klen_d[0] = '0;
      kc_d = 1'b0; lvl_d = '0; tag_d = 1'b0; cons_d = 32'd0; hold_d = 1'b0;
      done_d = 1'b0;
    end
  end

  assign sts_o.hold       = hold_q;
  assign sts_o.need_pop   = fin;
  assign sts_o.pop_last   = (is_map_q[lvl_q] && !wv_q[lvl_q]) || (cdec != 64'd0) ||
                            (lvl_q == '0);
  assign sts_o.emit_valid = fin_valid;
  assign sts_o.out_busy   = ov_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q <= 5'd16;
      phase_q <= dcsv_pkg::PhHead; head_shift_q <= 64'd0; head_floor_q <= 64'd0;
      hbl_q <= 4'd0; cur_major_q <= 3'd0; str_left_q <= 64'd0;
      for (int i = 0; i < Lvls; i++) begin
        cnt_q[i] <= (i == 0) ? 64'd1 : 64'd0;
        is_map_q[i] <= 1'b0; wv_q[i] <= 1'b0; has_key_q[i] <= 1'b0; klen_q[i] <= '0;
      end
      kc_q <= 1'b0; lvl_q <= '0; tag_q <= 1'b0; cons_q <= 32'd0; hold_q <= 1'b0;
      done_q <= 1'b0; pv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_depth_q <= cfg_wdata_i;
      phase_q <= phase_d; head_shift_q <= head_shift_d; head_floor_q <= head_floor_d;
      hbl_q <= hbl_d; cur_major_q <= cur_major_d; str_left_q <= str_left_d;
      cnt_q <= cnt_d; is_map_q <= is_map_d; wv_q <= wv_d; has_key_q <= has_key_d;
      klen_q <= klen_d;
      kc_q <= kc_d; lvl_q <= lvl_d; tag_q <= tag_d; cons_q <= cons_d; hold_q <= hold_d;
      done_q <= done_d; pv_q <= pv_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= data_byte_i;
      end_q  <= end_of_buffer_i;
    end
    pkind_q <= pkind_d; pmaj_q <= pmaj_d; parg_q <= parg_d; ppb_q <= ppb_d;
    plvl_q <= plvl_d; pkey_q <= pkey_d; perr_q <= perr_d;
    okind_q <= okind_d; omaj_q <= omaj_d; oarg_q <= oarg_d; opb_q <= opb_d;
    olvl_q <= olvl_d; okey_q <= okey_d; odone_q <= odone_d; ocons_q <= ocons_d;
    oerr_q <= oerr_d;
  end

  assign out_valid_o      = ov_q;
  assign result_kind_o    = okind_q;
  assign major_type_o     = omaj_q;
  assign argument_o       = oarg_q;
  assign payload_byte_o   = opb_q;
  assign nest_level_o     = 5'(olvl_q);
  assign is_map_key_o     = okey_q;
  assign object_done_o    = odone_q;
  assign bytes_consumed_o = ocons_q;
  assign error_code_o     = oerr_q;

endmodule

@@ src/dag_cbor_stream_validator.sv @@
// DAG-CBOR stream validator, top level: controller plus datapath.
// Depends on dcsv_pkg, dcsv_ctrl, dcsv_datapath.
//
// Takes one byte per input transfer and gives at most one result per byte
// (head, string payload byte or error). A byte passes through the accept,
// decode and result hand-off states; one that completes an item also passes
// through the pop state, where the pop sequencer steps the count stack and
// walks it one level per cycle. A byte skipped after an error skips hand-off
// and gives no result. Key bytes are checked against the previous key held
// in a 1088-entry key RAM read in the accept cycle. The result sits in an
// output register, so the next byte is taken while it waits. max_depth is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while
// idle, as the block does not enforce this. It resets to 16.
module dag_cbor_stream_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [2:0]  major_type_o,
  output logic [63:0] argument_o,
  output logic [7:0]  payload_byte_o,
  output logic [4:0]  nest_level_o,
  output logic        is_map_key_o,
  output logic        object_done_o,
  output logic [31:0] bytes_consumed_o,
  output logic [3:0]  error_code_o
);

  dcsv_pkg::dcsv_cmd_t cmd;
  dcsv_pkg::dcsv_sts_t sts;

  dcsv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dcsv_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .major_type_o    (major_type_o),
    .argument_o      (argument_o),
    .payload_byte_o  (payload_byte_o),
    .nest_level_o    (nest_level_o),
    .is_map_key_o    (is_map_key_o),
    .object_done_o   (object_done_o),
    .bytes_consumed_o(bytes_consumed_o),
    .error_code_o    (error_code_o)
  );

endmodule

@@ src/dcsv_checker.sv @@
// Port-level checks for the DAG-CBOR stream validator, bound to the top.
// Depends on dcsv_pkg and dag_cbor_stream_validator.
module dcsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [4:0]  nest_level_o,
  input logic        object_done_o,
  input logic [3:0]  error_code_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_kind_o != 2'd3)
    else $error("illegal result kind");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == dcsv_pkg::KindError) ==
                     (error_code_o != dcsv_pkg::ErrNone)))
    else $error("error code disagrees with kind");

  a_done_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && object_done_o |->
      nest_level_o <= 5'd16 && result_kind_o != dcsv_pkg::KindError)
    else $error("object done on error result");

endmodule

bind dag_cbor_stream_validator dcsv_checker u_dcsv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .result_kind_o(result_kind_o),
  .nest_level_o (nest_level_o),
  .object_done_o(object_done_o),
  .error_code_o (error_code_o)
);

@@ tb/sv/dag_cbor_stream_validator_tb.sv @@
// Testbench for dag_cbor_stream_validator: random and directed DAG-CBOR buffers,
// checked against a cycle-free predictor held in a small scoreboard class.
// Depends on dcsv_pkg and the dag_cbor_stream_validator RTL.
`timescale 1ns / 100ps

module dag_cbor_stream_validator_tb;
  import dcsv_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  major;
    logic [63:0] arg;
    logic [7:0]  pbyte;
    logic [4:0]  level;
    logic        key;
    logic        done;
    logic [31:0] consumed;
    logic [3:0]  err;
  } cbor_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } cbor_byte_t;

  class cbor_scoreboard;
    cbor_res_t   results_q[$];
    int          err_count;
    logic [4:0]  depth_reg;
    cbor_res_t   cur;
    logic [1:0]  phase;
    logic [63:0] shift, floor_v, str_left;
    int          arg_left;
    logic [2:0]  major;
    logic [63:0] lvl_count [MaxNest+1];
    logic        lvl_map [MaxNest+1];
    logic        lvl_val [MaxNest+1];
    logic [7:0]  lvl_klen [MaxNest+1];
    logic        lvl_has [MaxNest+1];
    logic [7:0]  key_mem [KeyStoreDepth];
    logic        key_cmp_eq;
    int          lvl;
    logic        tag_pend;
    logic [31:0] consumed;
    logic        hold;

    function new();
      foreach (key_mem[i]) key_mem[i] = 8'h00;
      depth_reg = 5'd16;
      err_count = 0;
      restart();
    endfunction

    function void restart();
      phase = PhHead; shift = 0; floor_v = 0; arg_left = 0; major = 0; str_left = 0;
      for (int i = 0; i <= MaxNest; i++) begin
        lvl_count[i] = 0; lvl_map[i] = 0; lvl_val[i] = 0; lvl_klen[i] = 0; lvl_has[i] = 0;
      end
      lvl_count[0] = 1;
      key_cmp_eq = 1; lvl = 0; tag_pend = 0; consumed = 0; hold = 0;
    endfunction

    function bit at_key();
      return lvl_map[lvl] && !lvl_val[lvl];
    endfunction

    function int fill(logic [1:0] k, logic [63:0] a, logic [7:0] pb, bit ky, logic [3:0] e);
      cur.kind = k; cur.major = major; cur.arg = a; cur.pbyte = pb; cur.level = lvl[4:0];
      cur.key = ky; cur.done = 0; cur.consumed = consumed; cur.err = e;
      return 1;
    endfunction

    function int fail(logic [3:0] e);
      return fill(KindError, 0, 0, at_key(), e);
    endfunction

    function bit close_item();
      forever begin
        if (lvl_map[lvl] && !lvl_val[lvl]) begin
          lvl_val[lvl] = 1;
          return 0;
        end
        lvl_val[lvl] = 0;
        lvl_count[lvl] = lvl_count[lvl] - 1;
        if (lvl_count[lvl] != 0) return 0;
        if (lvl == 0) return 1;
        lvl = lvl - 1;
      end
    endfunction

    function int head_complete(output bit done);
      logic [63:0] a;
      bit ky;
      int lim, l;
      a = shift; l = lvl; ky = at_key(); done = 0;
      lim = (depth_reg > MaxNest) ? MaxNest : depth_reg;
      case (major)
        MajBytes, MajText: begin
          if (ky) begin
            if (a > MaxKeyLen) return fail(ErrKeyTooLong);
            if (lvl_has[l] && a < lvl_klen[l]) return fail(ErrKeyOrder);
            if (lvl_has[l] && a == lvl_klen[l] && a == 0) return fail(ErrKeyOrder);
            key_cmp_eq = lvl_has[l] && a == lvl_klen[l];
            lvl_has[l] = 1;
            lvl_klen[l] = a[7:0];
          end else tag_pend = 0;
          void'(fill(KindHead, a, 0, ky, ErrNone));
          if (a == 0) done = close_item();
          else begin
            phase = PhStr;
            str_left = a;
          end
        end
        MajArray, MajMap: begin
          if (a != 0 && l + 1 > lim) return fail(ErrTooDeep);
          void'(fill(KindHead, a, 0, ky, ErrNone));
          if (a == 0) done = close_item();
          else begin
            lvl = l + 1;
            lvl_count[l+1] = a; lvl_map[l+1] = (major == MajMap);
            lvl_val[l+1] = 0; lvl_has[l+1] = 0; lvl_klen[l+1] = 0;
          end
        end
        MajTag: begin
          if (a != TagCid) return fail(ErrBadTag);
          tag_pend = 1;
          void'(fill(KindHead, a, 0, ky, ErrNone));
        end
        default: begin
          void'(fill(KindHead, a, 0, ky, ErrNone));
          done = close_item();
        end
      endcase
      return 1;
    endfunction

    function int head_byte(logic [7:0] b, output bit done);
      logic [4:0] info;
      info = b[4:0]; major = b[7:5]; done = 0;
      if (at_key() && major != MajText) return fail(ErrKeyNotText);
      if (tag_pend && major != MajBytes) return fail(ErrTagNotBytes);
      shift = 0;
      if (major == MajSimple) begin
        if (info >= 20 && info <= 22) begin
          shift = 64'(info);
          return head_complete(done);
        end
        if (info != 27) return fail(ErrBadSimple);
        arg_left = 8; floor_v = 0; phase = PhArg;
        return 0;
      end
      if (info < 24) begin
        shift = 64'(info);
        return head_complete(done);
      end
      if (info > 27) return fail(ErrBadInfo);
      case (info)
        24: begin arg_left = 1; floor_v = 64'd24; end
        25: begin arg_left = 2; floor_v = 64'h100; end
        26: begin arg_left = 4; floor_v = 64'h10000; end
        default: begin arg_left = 8; floor_v = 64'h1_0000_0000; end
      endcase
      phase = PhArg;
      return 0;
    endfunction

    function int string_byte(logic [7:0] b, output bit done);
      bit ky;
      logic [63:0] pos, idx;
      ky = at_key(); done = 0;
      if (ky) begin
        pos = lvl_klen[lvl] - str_left;
        idx = lvl * MaxKeyLen + pos;
        if (idx < KeyStoreDepth) begin
          if (key_cmp_eq) begin
            if (b < key_mem[idx]) return fail(ErrKeyOrder);
            if (b > key_mem[idx]) key_cmp_eq = 0;
          end
          key_mem[idx] = b;
        end
      end
      str_left = str_left - 1;
      if (str_left == 0) begin
        phase = PhHead;
        if (ky && key_cmp_eq) return fail(ErrKeyOrder);
        void'(fill(KindBytes, 0, b, ky, ErrNone));
        done = close_item();
        return 1;
      end
      return fill(KindBytes, 0, b, ky, ErrNone);
    endfunction

    function void note_input(logic [7:0] b, logic e);
      bit done;
      int n;
      done = 0;
      if (hold) begin
        if (e) restart();
        return;
      end
      if (consumed != 32'hffff_ffff) consumed = consumed + 1;
      if (phase == PhArg) begin
        shift = {shift[55:0], b};
        arg_left = arg_left - 1;
        n = 0;
        if (arg_left == 0) begin
          phase = PhHead;
          if (shift < floor_v) n = fail(ErrNonMinimal);
          else n = head_complete(done);
        end
      end else if (phase == PhStr) n = string_byte(b, done);
      else n = head_byte(b, done);
      if (done && n == 1) cur.done = 1;
      if (e && !done && (n == 0 || cur.kind != KindError)) n = fail(ErrTruncated);
      if (n == 1 && cur.kind == KindError) begin
        if (e) restart();
        else hold = 1;
      end else if (e || done) restart();
      if (n == 1) results_q.push_back(cur);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
      err_count++;
    endtask

    task check_result(cbor_res_t got);
      cbor_res_t w;
      if (results_q.size() == 0) begin
        report("unexpected result kind", got.kind, 0);
        return;
      end
      w = results_q.pop_front();
      if (got.kind != w.kind) report("result_kind", got.kind, w.kind);
      if (got.major != w.major) report("major_type", got.major, w.major);
      if (got.arg != w.arg) report("argument", got.arg, w.arg);
      if (got.pbyte != w.pbyte) report("payload_byte", got.pbyte, w.pbyte);
      if (got.level != w.level) report("nest_level", got.level, w.level);
      if (got.key != w.key) report("is_map_key", got.key, w.key);
      if (got.done != w.done) report("object_done", got.done, w.done);
      if (got.consumed != w.consumed) report("bytes_consumed", got.consumed, w.consumed);
      if (got.err != w.err) report("error_code", got.err, w.err);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = 5'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        end_of_buffer_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [2:0]  major_type_o;
  logic [63:0] argument_o;
  logic [7:0]  payload_byte_o;
  logic [4:0]  nest_level_o;
  logic        is_map_key_o;
  logic        object_done_o;
  logic [31:0] bytes_consumed_o;
  logic [3:0]  error_code_o;

  cbor_scoreboard sb = new();
  cbor_byte_t     stim_q[$];
  int             gap_pct, stall_pct, hold_left;

  dag_cbor_stream_validator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o, .data_byte_i,
    .end_of_buffer_i, .out_valid_o, .out_ready_i, .result_kind_o, .major_type_o,
    .argument_o, .payload_byte_o, .nest_level_o, .is_map_key_o, .object_done_o,
    .bytes_consumed_o, .error_code_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(data_byte_i, end_of_buffer_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({result_kind_o, major_type_o, argument_o, payload_byte_o,
                         nest_level_o, is_map_key_o, object_done_o, bytes_consumed_o,
                         error_code_o});
    end
  end

  function automatic void put(logic [7:0] b);
    stim_q.push_back({b, 1'b0});
  endfunction

  function automatic void end_buf();
    stim_q[stim_q.size()-1].e = 1'b1;
  endfunction

  function automatic void put_head(logic [2:0] maj, logic [63:0] v);
    int nb;
    if (v < 24) begin
      put({maj, v[4:0]});
      return;
    end
    if (v < 64'h100) begin put({maj, 5'd24}); nb = 1; end
    else if (v < 64'h10000) begin put({maj, 5'd25}); nb = 2; end
    else if (v < 64'h1_0000_0000) begin put({maj, 5'd26}); nb = 4; end
    else begin put({maj, 5'd27}); nb = 8; end
    for (int i = nb - 1; i >= 0; i--) put(v[i*8 +: 8]);
  endfunction

  function automatic logic [63:0] rand_arg();
    case ($urandom_range(4))
      0: return 64'($urandom_range(23));
      1: return 64'($urandom_range(255, 24));
      2: return 64'($urandom_range(65535, 256));
      3: return {32'd0, $urandom() | 32'h0001_0000};
      default: return {$urandom() | 32'h1, $urandom()};
    endcase
  endfunction

  function automatic void gen_value(int d);
    int k, n, len, base;
    logic [7:0] pre;
    bit eq_mode;
    k = $urandom_range((d < 3) ? 9 : 6);
    case (k)
      0: put_head(3'd0, rand_arg());
      1: put_head(3'd1, rand_arg());
      2, 3: begin
        len = $urandom_range(5);
        put_head(k[2:0], 64'(len));
        repeat (len) put(8'($urandom()));
      end
      4: begin
        put_head(MajTag, TagCid);
        len = $urandom_range(4);
        put_head(MajBytes, 64'(len));
        repeat (len) put(8'($urandom()));
      end
      5: put({MajSimple, 5'd20 + 5'($urandom_range(2))});
      6: begin
        put({MajSimple, 5'd27});
        repeat (8) put(8'($urandom()));
      end
      7: begin
        n = $urandom_range(3);
        put_head(MajArray, 64'(n));
        repeat (n) gen_value(d + 1);
      end
      default: begin
        n = $urandom_range(3);
        eq_mode = 1'($urandom_range(1));
        pre = 8'($urandom());
        base = $urandom_range(200);
        put_head(MajMap, 64'(n));
        for (int i = 0; i < n; i++) begin
          if (eq_mode) begin
            put_head(MajText, 64'd2);
            put(pre);
            put(8'(base + i));
          end else begin
            put_head(MajText, 64'(i));
            repeat (i) put(8'($urandom()));
          end
          gen_value(d + 1);
        end
      end
    endcase
  endfunction

  function automatic void gen_buffer();
    int s, cut;
    s = stim_q.size();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(6, 1)) put(8'($urandom()));
    end else begin
      gen_value(0);
      if ($urandom_range(99) < 10) gen_value(0);
      if ($urandom_range(99) < 8)
        stim_q[$urandom_range(stim_q.size() - 1, s)].b = 8'($urandom());
      if ($urandom_range(99) < 8 && stim_q.size() - s > 1) begin
        cut = $urandom_range(stim_q.size() - s - 1, 1);
        while (stim_q.size() > s + cut) void'(stim_q.pop_back());
      end
    end
    end_buf();
  endfunction

  task send_all();
    cbor_byte_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      if ($urandom_range(99) < gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(4, 1)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      data_byte_i <= it.b;
      end_of_buffer_i <= it.e;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;
  endtask

  task drain();
    while (sb.results_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task write_depth(logic [4:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.depth_reg = v;
    cfg_we_i <= 1'b0;
  endtask

  task run_phase(logic [4:0] depth, int gp, int sp, int nbytes, bit long_hold);
    write_depth(depth);
    gap_pct = gp;
    stall_pct = sp;
    while (stim_q.size() < nbytes) gen_buffer();
    fork
      send_all();
      if (long_hold) begin
        repeat (30) @(posedge clk_i);
        hold_left = 400;
      end
    join
    drain();
  endtask

  initial begin
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every error, float, trailing object, truncation
    put(8'h00); end_buf();
    put(8'h1b); repeat (8) put(8'hff); end_buf();
    put(8'h18); put(8'h05); end_buf();
    put(8'h1c); end_buf();
    put(8'hf7); end_buf();
    put(8'hd8); put(8'd43); end_buf();
    put(8'hd8); put(8'd42); put(8'h01); end_buf();
    put(8'ha1); put(8'h01); put(8'h01); end_buf();
    put(8'ha2); put(8'h61); put(8'h62); put(8'h00); put(8'h61); put(8'h61); put(8'h00);
    end_buf();
    put(8'ha2); put(8'h61); put(8'h61); put(8'h00); put(8'h61); put(8'h61); put(8'h00);
    end_buf();
    put(8'ha2); put(8'h60); put(8'h00); put(8'h60); put(8'h00); end_buf();
    put(8'ha1); put(8'h78); put(8'd65); put(8'h00); end_buf();
    repeat (17) put(8'h81); put(8'h00); end_buf();
    put(8'h82); put(8'h01); end_buf();
    put(8'h01); put(8'h02); end_buf();
    put(8'hfb); repeat (8) put(8'($urandom())); end_buf();
    put(8'hf4); put(8'hf5); put(8'hf6); put(8'h80); put(8'ha0); end_buf();
    put(8'h5f); put(8'hff); end_buf();
    send_all();
    drain();

    run_phase(5'd16, 0, 0, 280, 0);
    run_phase(5'd1, 49, 0, 280, 0);
    run_phase(5'd3, 0, 49, 280, 1);
    run_phase(5'd31, 28, 28, 280, 0);
    run_phase(5'd0, 0, 0, 140, 0);
    run_phase(5'd2, 28, 28, 280, 0);

    if (sb.err_count == 0 && sb.results_q.size() == 0) begin
      $display("dag_cbor_stream_validator verification clean");
    end else begin
      $display("dag_cbor_stream_validator verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("dag_cbor_stream_validator verification failed");
    $finish;
  end

endmodule
